/* rtl/pmid_pkg.sv */
// Shared constants and register codes for the periodic minimum-image distance block.
`timescale 1ns / 1ps
`default_nettype none
package pmid_pkg;

  localparam int COORD_BITS_DEF = 26;
  localparam int APB_DATA_BITS  = 32;
  localparam int APB_ADDR_BITS  = 4;

  typedef enum logic [1:0] {
    REG_BOX_X = 2'd0,
    REG_BOX_Y = 2'd1,
    REG_BOX_Z = 2'd2
  } reg_idx_t;

endpackage
`default_nettype wire

/* rtl/pmid_wrap.sv */
// Two-stage periodic wrap of one axis, giving the magnitude of the minimum-image difference.
`timescale 1ns / 1ps
`default_nettype none
module pmid_wrap #(
  parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [COORD_BITS-1:0] first,
  input  wire logic [COORD_BITS-1:0] second,
  input  wire logic [COORD_BITS-1:0] box,
  output logic      [COORD_BITS-1:0] mag
);

  localparam int DW = COORD_BITS + 2;

  logic signed [DW-1:0] diff_c;
  logic signed [DW-1:0] twice_c;
  logic signed [DW-1:0] len_c;
  logic                 ge_c;
  logic                 lt_c;

  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] len;
  logic                 ge;
  logic                 lt;

  logic signed [DW-1:0] wrapped_c;
  logic signed [DW-1:0] abs_c;

  always_comb begin
    diff_c  = $signed({2'b00, second}) - $signed({2'b00, first});
    twice_c = diff_c <<< 1;
    len_c   = $signed({2'b00, box});
    ge_c    = twice_c >= len_c;
    lt_c    = twice_c < -len_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= diff_c;
      len  <= len_c;
      ge   <= ge_c;
      lt   <= lt_c;
    end
  end

  always_comb begin
    priority if (ge) begin
      wrapped_c = diff - len;
    end else if (lt) begin
      wrapped_c = diff + len;
    end else begin
      wrapped_c = diff;
    end
    abs_c = wrapped_c[DW-1] ? -wrapped_c : wrapped_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= abs_c[COORD_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/pmid_sqrt_cell.sv */
// One cell of the square-root chain: settles one root bit and passes its state on.
`timescale 1ns / 1ps
`default_nettype none
module pmid_sqrt_cell #(
  parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic                    in_sat,
  input  wire logic [2*COORD_BITS-1:0] in_rad,
  input  wire logic [COORD_BITS:0]     in_rem,
  input  wire logic [COORD_BITS-1:0]   in_root,
  output logic                         out_valid,
  output logic                         out_sat,
  output logic      [2*COORD_BITS-1:0] out_rad,
  output logic      [COORD_BITS:0]     out_rem,
  output logic      [COORD_BITS-1:0]   out_root
);

  localparam int W = COORD_BITS;

  logic [W+2:0] cur_c;
  logic [W+2:0] trial_c;
  logic         take_c;
  logic [W+2:0] diff_c;

  always_comb begin
    cur_c   = {in_rem, in_rad[2*W-1 -: 2]};
    trial_c = {1'b0, in_root, 2'b01};
    take_c  = cur_c >= trial_c;
    diff_c  = cur_c - trial_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sat  <= in_sat;
      out_rad  <= {in_rad[2*W-3:0], 2'b00};
      out_rem  <= take_c ? diff_c[W:0] : cur_c[W:0];
      out_root <= {in_root[W-2:0], take_c};
    end
  end

endmodule
`default_nettype wire

/* rtl/periodic_min_image_distance.sv */
// Top level of the periodic minimum-image distance block.
`timescale 1ns / 1ps
`default_nettype none
// Takes two particle positions per item and returns the floor square root of the
// wrapped squared separation, with the same fraction bits as the inputs. The block
// accepts one item every clock cycle while the output is not stalled. Each result
// passes through the per-axis wrapping registers, the squaring register, the summing
// registers with saturation, one cell per root bit in the square-root chain, and the
// output register. When the output is stalled the whole pipeline holds. The box lengths are
// written over the APB port at byte addresses 0, 4 and 8 and reset to all ones.
module periodic_min_image_distance #(
  parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pmid_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [pmid_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [pmid_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                     pready,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire logic [COORD_BITS-1:0]               first_x,
  input  wire logic [COORD_BITS-1:0]               first_y,
  input  wire logic [COORD_BITS-1:0]               first_z,
  input  wire logic [COORD_BITS-1:0]               second_x,
  input  wire logic [COORD_BITS-1:0]               second_y,
  input  wire logic [COORD_BITS-1:0]               second_z,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic      [COORD_BITS-1:0]               pair_distance
);

  localparam int W  = COORD_BITS;
  localparam int SW = 2 * COORD_BITS;

  logic [W-1:0] box_x;
  logic [W-1:0] box_y;
  logic [W-1:0] box_z;
  logic         cfg_write;
  pmid_pkg::reg_idx_t cfg_idx;

  logic en;
  logic [4:0] vld;

  logic [W-1:0]  mag_x;
  logic [W-1:0]  mag_y;
  logic [W-1:0]  mag_z;
  logic [SW-1:0] sq_x;
  logic [SW-1:0] sq_y;
  logic [SW-1:0] sq_z;
  logic [SW:0]   sum_xy;
  logic [SW-1:0] sq_z_d;
  logic [SW+1:0] sum_c;
  logic [SW-1:0] rad;
  logic          sat;

  logic          c_vld  [0:W];
  logic          c_sat  [0:W];
  logic [SW-1:0] c_rad  [0:W];
  logic [W:0]    c_rem  [0:W];
  logic [W-1:0]  c_root [0:W];

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = pmid_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x <= '1;
      box_y <= '1;
      box_z <= '1;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        pmid_pkg::REG_BOX_X: box_x <= pwdata[W-1:0];
        pmid_pkg::REG_BOX_Y: box_y <= pwdata[W-1:0];
        pmid_pkg::REG_BOX_Z: box_z <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pmid_pkg::REG_BOX_X: prdata = pmid_pkg::APB_DATA_BITS'(box_x);
      pmid_pkg::REG_BOX_Y: prdata = pmid_pkg::APB_DATA_BITS'(box_y);
      pmid_pkg::REG_BOX_Z: prdata = pmid_pkg::APB_DATA_BITS'(box_z);
      default:             prdata = '0;
    endcase
  end

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], item_valid};
    end
  end

  pmid_wrap #(.COORD_BITS(W)) u_wrap_x (
    .clk(clk), .en(en), .first(first_x), .second(second_x), .box(box_x), .mag(mag_x)
  );
  pmid_wrap #(.COORD_BITS(W)) u_wrap_y (
    .clk(clk), .en(en), .first(first_y), .second(second_y), .box(box_y), .mag(mag_y)
  );
  pmid_wrap #(.COORD_BITS(W)) u_wrap_z (
    .clk(clk), .en(en), .first(first_z), .second(second_z), .box(box_z), .mag(mag_z)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x <= mag_x * mag_x;
      sq_y <= mag_y * mag_y;
      sq_z <= mag_z * mag_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_xy <= {1'b0, sq_x} + {1'b0, sq_y};
      sq_z_d <= sq_z;
    end
  end

  assign sum_c = {1'b0, sum_xy} + {2'b00, sq_z_d};

  always_ff @(posedge clk) begin
    if (en) begin
      rad <= sum_c[SW-1:0];
      sat <= |sum_c[SW+1:SW];
    end
  end

  assign c_vld[0]  = vld[4];
  assign c_sat[0]  = sat;
  assign c_rad[0]  = rad;
  assign c_rem[0]  = '0;
  assign c_root[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_cell
    pmid_sqrt_cell #(.COORD_BITS(W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (c_vld[i]),
      .in_sat   (c_sat[i]),
      .in_rad   (c_rad[i]),
      .in_rem   (c_rem[i]),
      .in_root  (c_root[i]),
      .out_valid(c_vld[i+1]),
      .out_sat  (c_sat[i+1]),
      .out_rad  (c_rad[i+1]),
      .out_rem  (c_rem[i+1]),
      .out_root (c_root[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= c_vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair_distance <= c_sat[W] ? '1 : c_root[W];
    end
  end

endmodule
`default_nettype wire

/* sim/pmid_checker.sv */
// Checker that predicts and compares the pair distances of the minimum-image distance block.
`timescale 1ns / 1ps
module pmid_checker #(
  parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [pmid_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [pmid_pkg::APB_DATA_BITS-1:0] pwdata,
  input  wire logic                               pready,
  input  wire logic                               item_valid,
  input  wire logic                               item_stall,
  input  wire logic [COORD_BITS-1:0]              first_x,
  input  wire logic [COORD_BITS-1:0]              first_y,
  input  wire logic [COORD_BITS-1:0]              first_z,
  input  wire logic [COORD_BITS-1:0]              second_x,
  input  wire logic [COORD_BITS-1:0]              second_y,
  input  wire logic [COORD_BITS-1:0]              second_z,
  input  wire logic                               result_valid,
  input  wire logic                               result_stall,
  input  wire logic [COORD_BITS-1:0]              pair_distance,
  output int                                      error_count,
  output int                                      outstanding
);

  typedef logic [COORD_BITS-1:0] coord_t;

  coord_t box_len_x;
  coord_t box_len_y;
  coord_t box_len_z;
  coord_t expected_distances[$];
  coord_t wanted;

  function automatic longint unsigned axis_span(coord_t a, coord_t b, coord_t box);
    longint d;
    longint len;
    d = longint'(b) - longint'(a);
    len = longint'(box);
    if (2 * d >= len) begin
      d = d - len;
    end else if (2 * d < -len) begin
      d = d + len;
    end
    return (d < 0) ? longint'(-d) : d;
  endfunction

  function automatic coord_t min_image_distance(coord_t ax, coord_t ay, coord_t az,
                                                coord_t bx, coord_t by, coord_t bz,
                                                coord_t lx, coord_t ly, coord_t lz);
    longint unsigned mx;
    longint unsigned my;
    longint unsigned mz;
    longint unsigned sq;
    longint unsigned root;
    longint unsigned trial;
    mx = axis_span(ax, bx, lx);
    my = axis_span(ay, by, ly);
    mz = axis_span(az, bz, lz);
    sq = mx * mx + my * my + mz * mz;
    if (sq >= (64'd1 << (2 * COORD_BITS))) begin
      return '1;
    end
    root = 0;
    for (int i = COORD_BITS - 1; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= sq) begin
        root = trial;
      end
    end
    return coord_t'(root);
  endfunction

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      box_len_x <= '1;
      box_len_y <= '1;
      box_len_z <= '1;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (pmid_pkg::reg_idx_t'(paddr[3:2]))
          pmid_pkg::REG_BOX_X: box_len_x <= pwdata[COORD_BITS-1:0];
          pmid_pkg::REG_BOX_Y: box_len_y <= pwdata[COORD_BITS-1:0];
          pmid_pkg::REG_BOX_Z: box_len_z <= pwdata[COORD_BITS-1:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        expected_distances.push_back(min_image_distance(first_x, first_y, first_z,
                                                        second_x, second_y, second_z,
                                                        box_len_x, box_len_y, box_len_z));
      end
      if (result_valid && !result_stall) begin
        if (expected_distances.size() == 0) begin
          if (error_count < 10) begin
            $display("%0t: result %0d arrived with no item outstanding", $realtime,
                     pair_distance);
          end
          error_count++;
        end else begin
          wanted = expected_distances.pop_front();
          if (pair_distance !== wanted) begin
            if (error_count < 10) begin
              $display("%0t: pair_distance mismatch, expected %0d, got %0d", $realtime,
                       wanted, pair_distance);
            end
            error_count++;
          end
        end
      end
      outstanding <= expected_distances.size();
    end
  end

endmodule

/* sim/tb_periodic_min_image_distance.sv */
// Testbench top for the periodic minimum-image distance block: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module tb_periodic_min_image_distance;

  localparam int COORD_BITS = pmid_pkg::COORD_BITS_DEF;
  localparam int LATENCY = COORD_BITS + 6;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;

  localparam coord_t MAXC = '1;
  localparam coord_t HALF = coord_t'(1) << (COORD_BITS - 1);
  localparam coord_t ONE = coord_t'(1) << 16;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [pmid_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [pmid_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [pmid_pkg::APB_DATA_BITS-1:0] prdata;
  logic pready;
  logic item_valid;
  logic item_stall;
  coord_t first_x, first_y, first_z;
  coord_t second_x, second_y, second_z;
  logic result_valid;
  logic result_stall;
  coord_t pair_distance;

  int error_count;
  int outstanding;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit hold_req;
  coord_t cur_box_x, cur_box_y, cur_box_z;

  periodic_min_image_distance #(.COORD_BITS(COORD_BITS)) DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .result_valid(result_valid), .result_stall(result_stall),
    .pair_distance(pair_distance)
  );

  pmid_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .result_valid(result_valid), .result_stall(result_stall),
    .pair_distance(pair_distance),
    .error_count(error_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Downstream pacing; a requested hold keeps the output stalled long enough to fill the block.
  initial begin
    int hold_left;
    hold_left = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx,
                           input logic [pmid_pkg::APB_DATA_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Upper data bits are filled with noise; the block keeps only the coordinate bits.
  task automatic set_boxes(input coord_t bx, input coord_t by, input coord_t bz);
    item_valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
    apb_write(pmid_pkg::REG_BOX_X, {6'($urandom), bx});
    apb_write(pmid_pkg::REG_BOX_Y, {6'($urandom), by});
    apb_write(pmid_pkg::REG_BOX_Z, {6'($urandom), bz});
    apb_write(REG_UNUSED, $urandom);
    cur_box_x = bx;
    cur_box_y = by;
    cur_box_z = bz;
  endtask

  task automatic push_pair(input coord_t ax, input coord_t ay, input coord_t az,
                           input coord_t bx, input coord_t by, input coord_t bz);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    first_x <= ax;
    first_y <= ay;
    first_z <= az;
    second_x <= bx;
    second_y <= by;
    second_z <= bz;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  function automatic coord_t pick_coord(coord_t box);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70 && box != 0) begin
      return coord_t'($urandom_range(box - 1, 0));
    end else if (sel < 78) begin
      return '0;
    end else if (sel < 86) begin
      return MAXC;
    end
    return coord_t'($urandom);
  endfunction

  task automatic random_pairs(input int count);
    for (int n = 0; n < count; n++) begin
      push_pair(pick_coord(cur_box_x), pick_coord(cur_box_y), pick_coord(cur_box_z),
                pick_coord(cur_box_x), pick_coord(cur_box_y), pick_coord(cur_box_z));
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_valid = 1'b0;
    first_x = '0;
    first_y = '0;
    first_z = '0;
    second_x = '0;
    second_y = '0;
    second_z = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    cur_box_x = MAXC;
    cur_box_y = MAXC;
    cur_box_z = MAXC;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset box lengths: wrap boundaries on both sides, exact squares, largest in-box span.
    push_pair('0, '0, '0, '0, '0, '0);
    push_pair('0, '0, '0, MAXC, MAXC, MAXC);
    push_pair(MAXC, MAXC, MAXC, '0, '0, '0);
    push_pair('0, '0, '0, HALF, '0, '0);
    push_pair('0, '0, '0, coord_t'(HALF - 1), '0, '0);
    push_pair(HALF, HALF, HALF, '0, '0, '0);
    push_pair(coord_t'(HALF - 1), coord_t'(HALF - 1), coord_t'(HALF - 1), '0, '0, '0);
    push_pair('0, '0, '0, coord_t'(3 * ONE), coord_t'(4 * ONE), '0);
    push_pair(ONE, ONE, ONE, coord_t'(ONE + 1), ONE, ONE);
    push_pair('0, '0, '0, coord_t'(HALF - 1), coord_t'(HALF - 1), coord_t'(HALF - 1));
    push_pair('0, ONE, '0, '0, '0, coord_t'(12 * ONE));
    push_pair(MAXC, '0, MAXC, '0, MAXC, '0);
    random_pairs(10);

    set_boxes(coord_t'(1), coord_t'(1), coord_t'(1));
    send_idle_pct = 83;
    stall_pct = 0;
    push_pair('0, '0, '0, MAXC, MAXC, MAXC);
    push_pair(ONE, '0, '0, '0, ONE, '0);
    random_pairs(90);

    set_boxes(MAXC, MAXC, MAXC);
    send_idle_pct = 0;
    stall_pct = 83;
    random_pairs(100);

    set_boxes(coord_t'($urandom_range(MAXC, 1)), coord_t'($urandom_range(MAXC, 1)),
              coord_t'($urandom_range(MAXC, 1)));
    send_idle_pct = 38;
    stall_pct = 38;
    random_pairs(100);

    // Zero box lengths: differences pass through and the result can saturate.
    set_boxes('0, '0, '0);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    push_pair('0, '0, '0, MAXC, MAXC, MAXC);
    push_pair(MAXC, MAXC, MAXC, '0, '0, '0);
    push_pair('0, '0, '0, MAXC, '0, '0);
    push_pair(coord_t'(5), '0, '0, '0, '0, '0);
    random_pairs(60);

    set_boxes(coord_t'($urandom_range(20'hFFFFF, 1)), MAXC, coord_t'(1));
    send_idle_pct = 38;
    stall_pct = 38;
    random_pairs(50);
    send_idle_pct = 0;
    stall_pct = 0;
    random_pairs(50);

    item_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (LATENCY + 10) @(negedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* periodic_min_image_distance.f */
rtl/pmid_pkg.sv
rtl/pmid_wrap.sv
rtl/pmid_sqrt_cell.sv
rtl/periodic_min_image_distance.sv
sim/pmid_checker.sv
sim/tb_periodic_min_image_distance.sv
